[rtl/core/o1ps_pkg.sv]
// Shared types, codes and constants of the O(1) priority task scheduler.
`default_nettype none
package o1ps_pkg;

  localparam int NUM_PRIO_DEF  = 32;
  localparam int NUM_TASKS_DEF = 64;

  localparam int FUNC_W  = 2;
  localparam int ID_W    = 6;
  localparam int PRIO_W  = 5;
  localparam int SLICE_W = 9;
  localparam int STAT_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_ENQ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PICK = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_PRIO = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic enq_wr;
    logic pk_link;
    logic pk_done;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic enq_go;
    logic pick_go;
  } stat_t;

  function automatic logic signed [SLICE_W-1:0] sat_m1(input logic signed [SLICE_W-1:0] v);
    return (v < -9'sd1) ? -9'sd1 : v;
  endfunction

endpackage
`default_nettype wire

[rtl/core/o1ps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module o1ps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/o1ps_ctrl.sv]
// Sequencing state machine of the scheduler.
`default_nettype none
module o1ps_ctrl import o1ps_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire stat_t st,
  output logic       busy,
  output cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_ENQ     = 4'b0010,
    S_PK_LINK = 4'b0100,
    S_PK_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (st.enq_go) begin
            state_next = S_ENQ;
          end else if (st.pick_go) begin
            state_next = S_PK_LINK;
          end
        end
      end
      S_ENQ: begin
        cmd.enq_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_PK_LINK: begin
        cmd.pk_link = 1'b1;
        state_next  = S_PK_DONE;
      end
      S_PK_DONE: begin
        cmd.pk_done = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  a_enq_one: assert property (@(posedge clk) disable iff (rst)
    state == S_ENQ |=> state == S_IDLE) else $error("enqueue write not single cycle");
  a_pick_seq: assert property (@(posedge clk) disable iff (rst)
    state == S_PK_LINK |=> state == S_PK_DONE) else $error("pick sequence broken");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> !busy) else $error("transaction accepted while busy");

endmodule
`default_nettype wire

[rtl/core/o1ps_dp.sv]
// Scheduler datapath: queue memories, occupancy bitmaps, counts, result registers.
`default_nettype none
module o1ps_dp import o1ps_pkg::*; #(
  parameter int NUM_PRIO  = NUM_PRIO_DEF,
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cmd_t                      cmd,
  input  wire logic [FUNC_W-1:0]         func,
  input  wire logic [ID_W-1:0]           task_id,
  input  wire logic [PRIO_W-1:0]         task_prio,
  input  wire logic signed [SLICE_W-1:0] slice_in,
  output stat_t                          st,
  output logic                           done,
  output logic [ID_W-1:0]                picked_task,
  output logic signed [SLICE_W-1:0]      slice_out,
  output logic                           resched,
  output logic [STAT_W-1:0]              status
);

  localparam int IW    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int PW    = (NUM_PRIO > 1) ? $clog2(NUM_PRIO) : 1;
  localparam int QD    = 2 * NUM_PRIO;
  localparam int QW    = $clog2(QD);
  localparam int CNT_W = 16;
  localparam int IDS   = 2 ** ID_W;

  function automatic logic [QW-1:0] qaddr(input logic a, input logic [PW-1:0] p);
    return a ? (QW'(NUM_PRIO) + QW'(p)) : QW'(p);
  endfunction

  // task id reduced modulo the task count, as a constant table
  logic [IW-1:0] id_tab [IDS];
  for (genvar g = 0; g < IDS; g++) begin : g_idtab
    assign id_tab[g] = IW'(g % NUM_TASKS);
  end

  logic [NUM_PRIO-1:0] occ [2];
  logic [CNT_W-1:0]    cnt [2];
  logic                act;

  logic [QW-1:0] q_r;
  logic [IW-1:0] id_r, h_r, t_r;
  logic [PW-1:0] p_r;
  logic          arr_r;

  logic [IW-1:0] head_rd, tail_rd, link_rd;

  logic [IW-1:0] id_m;
  logic          prio_ok, enq_arr, a_sel, found, pick_ok;
  logic [PW-1:0] pi, pf;
  logic [QW-1:0] q_in;
  logic signed [SLICE_W-1:0] enq_slice, tick_slice;
  logic          occ_bit;

  always_comb begin
    id_m    = id_tab[task_id];
    prio_ok = (task_prio != '0) && (32'(task_prio) < 32'(NUM_PRIO));
    pi      = PW'(task_prio);
    enq_arr = (slice_in < 0) ? ~act : act;
    a_sel   = (cnt[act] == '0) ? ~act : act;
    found   = 1'b0;
    pf      = '0;
    for (int i = NUM_PRIO - 1; i >= 0; i--) begin
      if (occ[a_sel][i]) begin
        found = 1'b1;
        pf    = PW'(i);
      end
    end
    pick_ok = (cnt[a_sel] != '0) && found;
    q_in    = (func == FUNC_PICK) ? qaddr(a_sel, pf) : qaddr(enq_arr, pi);

    // new task with a zero slice gets NUM_PRIO - prio
    if (prio_ok && slice_in == 0) begin
      enq_slice = SLICE_W'(32'(NUM_PRIO) - 32'(task_prio));
    end else begin
      enq_slice = sat_m1(slice_in);
    end
    tick_slice = sat_m1((slice_in >= 0) ? slice_in - 9'sd1 : slice_in);

    st.enq_go  = (func == FUNC_ENQ) && prio_ok;
    st.pick_go = (func == FUNC_PICK) && pick_ok;
    occ_bit    = occ[arr_r][p_r];
  end

  logic          head_we, tail_we, link_we;
  logic [IW-1:0] head_wd;
  logic [QW-1:0] q_rd;

  assign q_rd    = cmd.accept ? q_in : q_r;
  assign head_we = (cmd.enq_wr && !occ_bit) || (cmd.pk_done && h_r != t_r);
  assign head_wd = cmd.enq_wr ? id_r : link_rd;
  assign tail_we = cmd.enq_wr;
  assign link_we = cmd.enq_wr && occ_bit;

  o1ps_ram #(.WIDTH(IW), .DEPTH(QD)) u_head (
    .clk(clk), .we(head_we), .waddr(q_r), .wdata(head_wd), .raddr(q_rd), .rdata(head_rd)
  );
  o1ps_ram #(.WIDTH(IW), .DEPTH(QD)) u_tail (
    .clk(clk), .we(tail_we), .waddr(q_r), .wdata(id_r), .raddr(q_rd), .rdata(tail_rd)
  );
  o1ps_ram #(.WIDTH(IW), .DEPTH(NUM_TASKS)) u_link (
    .clk(clk), .we(link_we), .waddr(tail_rd), .wdata(id_r), .raddr(head_rd), .rdata(link_rd)
  );

  // transaction registers and result fields
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      q_r   <= q_in;
      id_r  <= id_m;
      p_r   <= (func == FUNC_PICK) ? pf : pi;
      arr_r <= (func == FUNC_PICK) ? a_sel : enq_arr;
      picked_task <= '0;
      slice_out   <= '0;
      resched     <= 1'b0;
      status      <= ST_OK;
      case (func)
        FUNC_ENQ: begin
          slice_out <= enq_slice;
          status    <= prio_ok ? ST_OK : ST_BAD_PRIO;
        end
        FUNC_PICK: begin
          status <= pick_ok ? ST_OK : ST_EMPTY;
        end
        FUNC_TICK: begin
          slice_out <= tick_slice;
          resched   <= tick_slice[SLICE_W-1];
        end
        default: ;
      endcase
    end
    if (cmd.pk_link) begin
      h_r <= head_rd;
      t_r <= tail_rd;
    end
    if (cmd.pk_done) begin
      picked_task <= ID_W'(h_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ[0] <= '0;
      occ[1] <= '0;
      cnt[0] <= '0;
      cnt[1] <= '0;
      act    <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= (cmd.accept && !st.enq_go && !st.pick_go) || cmd.enq_wr || cmd.pk_done;
      if (cmd.accept && func == FUNC_PICK) begin
        act <= a_sel;
      end
      if (cmd.enq_wr) begin
        occ[arr_r][p_r] <= 1'b1;
        cnt[arr_r]      <= cnt[arr_r] + 1'b1;
      end
      if (cmd.pk_done) begin
        if (h_r == t_r) begin
          occ[arr_r][p_r] <= 1'b0;
        end
        cnt[arr_r] <= cnt[arr_r] - 1'b1;
      end
    end
  end

  a_pick_occ: assert property (@(posedge clk) disable iff (rst)
    cmd.pk_done |-> occ[arr_r][p_r] && cnt[arr_r] != '0) else $error("pick on empty level");
  a_enq_set: assert property (@(posedge clk) disable iff (rst)
    cmd.enq_wr |=> occ[$past(arr_r)][$past(p_r)]) else $error("enqueue left level empty");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_EMPTY |-> picked_task == '0) else $error("empty pick returned a task");

endmodule
`default_nettype wire

[rtl/core/o1_priority_task_scheduler.sv]
// O(1) priority task scheduler: active/expired arrays of per-priority FIFOs.
// Tick, no-op, bad-priority enqueue, empty pick: result is registered on accept.
// Enqueue: tail read, then link/head/tail write. Pick: head/tail read, link read,
// then update; these steps are set by the registered queue RAM reads.
// One transaction at a time; done pulses one cycle with the result, no backpressure.
// Synchronous reset empties both arrays and makes array 0 active; RAMs are not cleared.
`default_nettype none
module o1_priority_task_scheduler import o1ps_pkg::*; #(
  parameter int NUM_PRIO  = NUM_PRIO_DEF,
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [FUNC_W-1:0]         func,
  input  wire logic [ID_W-1:0]           task_id,
  input  wire logic [PRIO_W-1:0]         task_prio,
  input  wire logic signed [SLICE_W-1:0] slice_in,
  output logic                           done,
  output logic [ID_W-1:0]                picked_task,
  output logic signed [SLICE_W-1:0]      slice_out,
  output logic                           resched,
  output logic [STAT_W-1:0]              status
);

  cmd_t  cmd;
  stat_t st;

  o1ps_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .st(st), .busy(busy), .cmd(cmd)
  );

  o1ps_dp #(.NUM_PRIO(NUM_PRIO), .NUM_TASKS(NUM_TASKS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .func(func), .task_id(task_id),
    .task_prio(task_prio), .slice_in(slice_in), .st(st), .done(done),
    .picked_task(picked_task), .slice_out(slice_out), .resched(resched), .status(status)
  );

endmodule
`default_nettype wire

[tb/o1ps_checker.sv]
// Scheduler checker: watches command and result channels, predicts results and compares.
`timescale 1ns / 100ps
module o1ps_checker import o1ps_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic                      busy,
  input  wire logic [FUNC_W-1:0]         func,
  input  wire logic [ID_W-1:0]           task_id,
  input  wire logic [PRIO_W-1:0]         task_prio,
  input  wire logic signed [SLICE_W-1:0] slice_in,
  input  wire logic                      done,
  input  wire logic [ID_W-1:0]           picked_task,
  input  wire logic signed [SLICE_W-1:0] slice_out,
  input  wire logic                      resched,
  input  wire logic [STAT_W-1:0]         status,
  output int                             errors,
  output int                             pending
);

  typedef struct packed {
    logic [ID_W-1:0]           picked;
    logic signed [SLICE_W-1:0] slice;
    logic                      resched;
    logic [STAT_W-1:0]         status;
  } sched_result_t;

  // scheduler shadow state
  logic [ID_W-1:0] link_nxt [NUM_TASKS_DEF];
  logic [ID_W-1:0] fifo_head[2*NUM_PRIO_DEF];
  logic [ID_W-1:0] fifo_tail[2*NUM_PRIO_DEF];
  logic [NUM_PRIO_DEF-1:0] occ[2];
  logic [15:0] tasks_queued[2];
  logic active_arr;

  sched_result_t expected_q[$];

  function automatic logic signed [SLICE_W-1:0] clamp_slice(int v);
    if (v < -1) v = -1;
    return v[SLICE_W-1:0];
  endfunction

  function automatic void append_task(logic arr, int prio, logic [ID_W-1:0] id);
    int q;
    q = arr * NUM_PRIO_DEF + prio;
    if (!occ[arr][prio]) fifo_head[q] = id;
    else link_nxt[fifo_tail[q]] = id;
    fifo_tail[q] = id;
    occ[arr][prio] = 1'b1;
    tasks_queued[arr] = tasks_queued[arr] + 16'd1;
  endfunction

  function automatic sched_result_t schedule_step(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                                                  logic [PRIO_W-1:0] prio,
                                                  logic signed [SLICE_W-1:0] sl);
    sched_result_t r;
    int s;
    int p;
    int q;
    logic [ID_W-1:0] h;
    r = '0;
    s = sl;
    case (f)
      FUNC_ENQ: begin
        if (prio == 0) begin
          r.status = ST_BAD_PRIO;
        end else if (s > 0) begin
          append_task(active_arr, prio, id);
        end else if (s == 0) begin
          s = NUM_PRIO_DEF - prio;
          append_task(active_arr, prio, id);
        end else begin
          append_task(!active_arr, prio, id);
        end
        r.slice = clamp_slice(s);
      end
      FUNC_PICK: begin
        if (tasks_queued[active_arr] == 0) active_arr = !active_arr;
        p = -1;
        if (tasks_queued[active_arr] != 0)
          for (int i = NUM_PRIO_DEF - 1; i >= 0; i--)
            if (occ[active_arr][i]) p = i;
        if (p < 0) begin
          r.status = ST_EMPTY;
        end else begin
          q = active_arr * NUM_PRIO_DEF + p;
          h = fifo_head[q];
          if (h == fifo_tail[q]) occ[active_arr][p] = 1'b0;
          else fifo_head[q] = link_nxt[h];
          tasks_queued[active_arr] = tasks_queued[active_arr] - 16'd1;
          r.picked = h;
        end
      end
      FUNC_TICK: begin
        if (s >= 0) s = s - 1;
        r.resched = (s < 0);
        r.slice = clamp_slice(s);
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    for (int i = 0; i < NUM_TASKS_DEF; i++) link_nxt[i] = '0;
    for (int i = 0; i < 2*NUM_PRIO_DEF; i++) begin
      fifo_head[i] = '0;
      fifo_tail[i] = '0;
    end
  end

  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t exp_r;
    if (rst) begin
      occ[0] = '0;
      occ[1] = '0;
      tasks_queued[0] = '0;
      tasks_queued[1] = '0;
      active_arr = 1'b0;
      expected_q.delete();
      pending = 0;
    end else begin
      if (done) begin
        got = '{picked_task, slice_out, resched, status};
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h, nothing pending", $realtime, got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got.picked !== exp_r.picked) begin
            errors++;
            $display("%0t: picked_task exp %0d got %0d", $realtime, exp_r.picked, got.picked);
          end
          if (got.slice !== exp_r.slice) begin
            errors++;
            $display("%0t: slice_out exp %0d got %0d", $realtime, exp_r.slice, got.slice);
          end
          if (got.resched !== exp_r.resched) begin
            errors++;
            $display("%0t: resched exp %0d got %0d", $realtime, exp_r.resched, got.resched);
          end
          if (got.status !== exp_r.status) begin
            errors++;
            $display("%0t: status exp %0d got %0d", $realtime, exp_r.status, got.status);
          end
        end
      end
      // a transaction accepted this edge yields its result at a later edge
      if (start && !busy)
        expected_q.push_back(schedule_step(func, task_id, task_prio, slice_in));
      pending = expected_q.size();
    end
  end

endmodule

[tb/tb_top.sv]
// Testbench top for the O(1) priority task scheduler: stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
  import o1ps_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_IDLE = 2'd3;
  localparam int MAX_QUEUED = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [FUNC_W-1:0] func = FUNC_ENQ;
  logic [ID_W-1:0] task_id = '0;
  logic [PRIO_W-1:0] task_prio = '0;
  logic signed [SLICE_W-1:0] slice_in = '0;
  logic busy, done, resched;
  logic [ID_W-1:0] picked_task;
  logic signed [SLICE_W-1:0] slice_out;
  logic [STAT_W-1:0] status;
  int errors, pending;

  int op_count[4];
  int queued_est;
  logic [ID_W-1:0] fresh_id;
  bit no_gaps;

  always #5 clk = ~clk;

  o1_priority_task_scheduler dut (.*);
  o1ps_checker chk (.*);

  task automatic issue(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
                       logic signed [SLICE_W-1:0] sl);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    task_id <= id;
    task_prio <= prio;
    slice_in <= sl;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    op_count[f]++;
    if (f == FUNC_ENQ && prio != 0) queued_est++;
    if (f == FUNC_PICK && queued_est > 0) queued_est--;
  endtask

  task automatic idle_until_drained();
    @(posedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_item();
    int roll;
    logic signed [SLICE_W-1:0] sl;
    logic [ID_W-1:0] id;
    roll = $urandom_range(0, 99);
    if (queued_est >= MAX_QUEUED && roll < 50) roll = 50;
    if (roll < 50) begin
      case ($urandom_range(0, 9))
        0, 1:    sl = 9'sd0;
        2:       sl = -9'sd1;
        3:       sl = 9'sd255;
        default: sl = $urandom_range(1, 255);
      endcase
      if ($urandom_range(0, 9) < 8) begin
        id = fresh_id;
        fresh_id++;
      end else begin
        id = $urandom_range(0, 63);
      end
      issue(FUNC_ENQ, id, ($urandom_range(0, 19) == 0) ? 5'd0 : $urandom_range(1, 31), sl);
    end else if (roll < 82) begin
      issue(FUNC_PICK, $urandom, $urandom, $urandom);
    end else if (roll < 97) begin
      issue(FUNC_TICK, $urandom, $urandom, $urandom_range(0, 256) - 1);
    end else begin
      issue(FUNC_IDLE, $urandom, $urandom, $urandom_range(0, 256) - 1);
    end
  endtask

  initial begin
    int n;
    queued_est = 0;
    fresh_id = '0;
    no_gaps = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // warm-up: every link entry gets written once, then both arrays drain to empty
    for (n = 0; n < NUM_TASKS_DEF; n++) issue(FUNC_ENQ, ID_W'(n), 5'd1, 9'sd1);
    issue(FUNC_ENQ, 6'd63, 5'd2, 9'sd1);
    issue(FUNC_ENQ, 6'd0, 5'd2, 9'sd1);
    repeat (NUM_TASKS_DEF + 2) issue(FUNC_PICK, 6'd0, 5'd0, 9'sd0);

    // directed: field extremes, both arrays, swap, empty, duplicates
    issue(FUNC_PICK, 6'd0, 5'd0, 9'sd0);
    issue(FUNC_ENQ, 6'd63, 5'd31, 9'sd0);
    issue(FUNC_ENQ, 6'd0, 5'd1, 9'sd255);
    issue(FUNC_ENQ, 6'd5, 5'd1, 9'sd1);
    issue(FUNC_ENQ, 6'd7, 5'd3, -9'sd1);
    issue(FUNC_ENQ, 6'd9, 5'd0, -9'sd1);
    issue(FUNC_ENQ, 6'd9, 5'd0, 9'sd0);
    issue(FUNC_ENQ, 6'd9, 5'd0, 9'sd255);
    repeat (5) issue(FUNC_PICK, 6'd63, 5'd31, 9'sd255);
    issue(FUNC_TICK, 6'd63, 5'd31, 9'sd255);
    issue(FUNC_TICK, 6'd1, 5'd2, 9'sd1);
    issue(FUNC_TICK, 6'd1, 5'd2, 9'sd0);
    issue(FUNC_TICK, 6'd1, 5'd2, -9'sd1);
    issue(FUNC_IDLE, 6'd63, 5'd31, -9'sd1);
    // same task queued twice, then stray entries left in the count
    issue(FUNC_ENQ, 6'd12, 5'd4, 9'sd10);
    issue(FUNC_ENQ, 6'd13, 5'd4, 9'sd10);
    issue(FUNC_ENQ, 6'd12, 5'd4, 9'sd10);
    repeat (4) issue(FUNC_PICK, 6'd0, 5'd0, 9'sd0);
    idle_until_drained();
    queued_est = 0;

    for (n = 0; n < 800; n++) begin
      if (n % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (n % 150 == 149) begin
        idle_until_drained();
        repeat (queued_est + 3) issue(FUNC_PICK, $urandom, $urandom, $urandom);
        queued_est = 0;
      end else begin
        random_item();
      end
    end

    @(posedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Run: %0d enqueues, %0d picks, %0d ticks, %0d no-ops, periodic drains to empty.",
             op_count[FUNC_ENQ], op_count[FUNC_PICK], op_count[FUNC_TICK],
             op_count[FUNC_IDLE]);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout, %0d transactions still pending", pending);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[o1_priority_task_scheduler.f]
rtl/core/o1ps_pkg.sv
rtl/core/o1ps_ram.sv
rtl/core/o1ps_ctrl.sv
rtl/core/o1ps_dp.sv
rtl/core/o1_priority_task_scheduler.sv
tb/o1ps_checker.sv
tb/tb_top.sv
